@@ hw/rtl/hvpe_pkg.sv @@
`default_nettype none

package hvpe_pkg;

  localparam int unsigned HVPE_QUEUE_DEPTH = 2;

  // operation codes carried on func
  localparam logic [4:0] OP_TICK         = 5'd0;
  localparam logic [4:0] OP_SIG_READ     = 5'd1;
  localparam logic [4:0] OP_RD_LFUSE     = 5'd2;
  localparam logic [4:0] OP_RD_HFUSE     = 5'd3;
  localparam logic [4:0] OP_RD_EFUSE     = 5'd4;
  localparam logic [4:0] OP_RD_LOCK      = 5'd5;
  localparam logic [4:0] OP_WR_LFUSE     = 5'd6;
  localparam logic [4:0] OP_WR_HFUSE     = 5'd7;
  localparam logic [4:0] OP_WR_EFUSE     = 5'd8;
  localparam logic [4:0] OP_WR_LOCK      = 5'd9;
  localparam logic [4:0] OP_ERASE        = 5'd10;
  localparam logic [4:0] OP_MODE_WR_FL   = 5'd11;
  localparam logic [4:0] OP_MODE_RD_FL   = 5'd12;
  localparam logic [4:0] OP_MODE_WR_EE   = 5'd13;
  localparam logic [4:0] OP_MODE_RD_EE   = 5'd14;
  localparam logic [4:0] OP_LOAD_FL_LO   = 5'd15;
  localparam logic [4:0] OP_LOAD_FL_HI   = 5'd16;
  localparam logic [4:0] OP_RD_FL_LO     = 5'd17;
  localparam logic [4:0] OP_RD_FL_HI     = 5'd18;
  localparam logic [4:0] OP_WR_FL_PAGE   = 5'd19;
  localparam logic [4:0] OP_LOAD_EE      = 5'd20;
  localparam logic [4:0] OP_WR_EE_PAGE   = 5'd21;

  // instruction bytes on sii
  localparam logic [7:0] INS_CMD     = 8'h4C;
  localparam logic [7:0] INS_ALO     = 8'h0C;
  localparam logic [7:0] INS_AHI     = 8'h1C;
  localparam logic [7:0] INS_DLO     = 8'h2C;
  localparam logic [7:0] INS_DHI     = 8'h3C;
  localparam logic [7:0] INS_PLS_LO  = 8'h64;
  localparam logic [7:0] INS_END_LO  = 8'h6C;
  localparam logic [7:0] INS_PLS_HI  = 8'h74;
  localparam logic [7:0] INS_END_HI  = 8'h7C;
  localparam logic [7:0] INS_PLS_EX  = 8'h66;
  localparam logic [7:0] INS_END_EX  = 8'h6E;
  localparam logic [7:0] INS_RD_LO   = 8'h68;
  localparam logic [7:0] INS_RD_HI   = 8'h78;
  localparam logic [7:0] INS_RD_HF   = 8'h7A;
  localparam logic [7:0] INS_END_HF  = 8'h7E;
  localparam logic [7:0] INS_RD_EX   = 8'h6A;
  localparam logic [7:0] INS_PAGE_HI = 8'h7D;
  localparam logic [7:0] INS_PAGE_EE = 8'h6D;

  // command bytes on sdi
  localparam logic [7:0] CMD_SIG     = 8'h08;
  localparam logic [7:0] CMD_RD_FUSE = 8'h04;
  localparam logic [7:0] CMD_WR_FUSE = 8'h40;
  localparam logic [7:0] CMD_WR_LOCK = 8'h20;
  localparam logic [7:0] CMD_ERASE   = 8'h80;
  localparam logic [7:0] CMD_WR_FL   = 8'h10;
  localparam logic [7:0] CMD_RD_FL   = 8'h02;
  localparam logic [7:0] CMD_WR_EE   = 8'h11;
  localparam logic [7:0] CMD_RD_EE   = 8'h03;

  localparam logic [2:0] NO_READ = 3'd7;

  // slot numbering inside a frame
  localparam logic [3:0] SLOT_IDLE     = 4'd0;
  localparam logic [3:0] SLOT_FIRST    = 4'd1;
  localparam logic [3:0] SLOT_LAST_BIT = 4'd8;
  localparam logic [3:0] SLOT_STOP1    = 4'd9;
  localparam logic [3:0] SLOT_STOP2    = 4'd10;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_START,
    KIND_UNKNOWN
  } item_kind_e;

  typedef enum logic [2:0] {
    SRC_CONST,
    SRC_HELD,
    SRC_ALO,
    SRC_AHI,
    SRC_PAGE
  } data_sel_e;

  typedef struct packed {
    data_sel_e  sel;
    logic [7:0] value;
  } data_src_t;

  typedef struct packed {
    item_kind_e  kind;
    logic [4:0]  op;
    logic [15:0] address;
    logic [7:0]  held;
    logic        sdo;
  } item_t;

  typedef struct packed {
    logic       sci_pulse;
    logic       sdi;
    logic       sii;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       rejected;
  } result_t;

  function automatic logic [2:0] frame_total(input logic [4:0] op);
    logic [2:0] n;
    case (op)
      OP_SIG_READ, OP_WR_LFUSE, OP_WR_HFUSE, OP_WR_EFUSE, OP_WR_LOCK,
      OP_RD_FL_LO, OP_RD_FL_HI:                               n = 3'd4;
      OP_RD_LFUSE, OP_RD_HFUSE, OP_RD_EFUSE, OP_RD_LOCK, OP_ERASE,
      OP_LOAD_FL_HI, OP_WR_FL_PAGE:                           n = 3'd3;
      OP_MODE_WR_FL, OP_MODE_RD_FL, OP_MODE_WR_EE, OP_MODE_RD_EE: n = 3'd1;
      OP_LOAD_FL_LO, OP_WR_EE_PAGE:                           n = 3'd2;
      OP_LOAD_EE:                                             n = 3'd5;
      default:                                                n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] read_frame(input logic [4:0] op);
    logic [2:0] f;
    case (op)
      OP_SIG_READ, OP_RD_FL_LO:                            f = 3'd3;
      OP_RD_LFUSE, OP_RD_HFUSE, OP_RD_EFUSE, OP_RD_LOCK,
      OP_RD_FL_HI:                                         f = 3'd2;
      default:                                             f = NO_READ;
    endcase
    return f;
  endfunction

  function automatic data_src_t data_src(input logic [4:0] op, input logic [2:0] fr);
    data_src_t s;
    s = '{sel: SRC_CONST, value: 8'h00};
    case (op)
      OP_SIG_READ: begin
        if (fr == 3'd0) s.value = CMD_SIG;
        else if (fr == 3'd1) s.sel = SRC_HELD;
      end
      OP_RD_LFUSE, OP_RD_HFUSE, OP_RD_EFUSE, OP_RD_LOCK: begin
        if (fr == 3'd0) s.value = CMD_RD_FUSE;
      end
      OP_WR_LFUSE, OP_WR_HFUSE, OP_WR_EFUSE: begin
        if (fr == 3'd0) s.value = CMD_WR_FUSE;
        else if (fr == 3'd1) s.sel = SRC_HELD;
      end
      OP_WR_LOCK: begin
        if (fr == 3'd0) s.value = CMD_WR_LOCK;
        else if (fr == 3'd1) s.sel = SRC_HELD;
      end
      OP_ERASE:      if (fr == 3'd0) s.value = CMD_ERASE;
      OP_MODE_WR_FL: if (fr == 3'd0) s.value = CMD_WR_FL;
      OP_MODE_RD_FL: if (fr == 3'd0) s.value = CMD_RD_FL;
      OP_MODE_WR_EE: if (fr == 3'd0) s.value = CMD_WR_EE;
      OP_MODE_RD_EE: if (fr == 3'd0) s.value = CMD_RD_EE;
      OP_LOAD_FL_LO: begin
        if (fr == 3'd0) s.sel = SRC_ALO;
        else if (fr == 3'd1) s.sel = SRC_HELD;
      end
      OP_LOAD_FL_HI: if (fr == 3'd0) s.sel = SRC_HELD;
      OP_RD_FL_LO: begin
        if (fr == 3'd0) s.sel = SRC_ALO;
        else if (fr == 3'd1) s.sel = SRC_AHI;
      end
      OP_WR_FL_PAGE: if (fr == 3'd0) s.sel = SRC_PAGE;
      OP_LOAD_EE: begin
        if (fr == 3'd0) s.sel = SRC_ALO;
        else if (fr == 3'd1) s.sel = SRC_AHI;
        else if (fr == 3'd2) s.sel = SRC_HELD;
      end
      default: s = '{sel: SRC_CONST, value: 8'h00};
    endcase
    return s;
  endfunction

  function automatic logic [7:0] instr_byte(input logic [4:0] op, input logic [2:0] fr);
    logic [7:0] b;
    b = 8'h00;
    case (op)
      OP_SIG_READ: begin
        case (fr)
          3'd0: b = INS_CMD;
          3'd1: b = INS_ALO;
          3'd2: b = INS_RD_LO;
          3'd3: b = INS_END_LO;
          default: b = 8'h00;
        endcase
      end
      OP_RD_LFUSE: begin
        case (fr)
          3'd0: b = INS_CMD;
          3'd1: b = INS_RD_LO;
          3'd2: b = INS_END_LO;
          default: b = 8'h00;
        endcase
      end
      OP_RD_HFUSE: begin
        case (fr)
          3'd0: b = INS_CMD;
          3'd1: b = INS_RD_HF;
          3'd2: b = INS_END_HF;
          default: b = 8'h00;
        endcase
      end
      OP_RD_EFUSE: begin
        case (fr)
          3'd0: b = INS_CMD;
          3'd1: b = INS_RD_EX;
          3'd2: b = INS_END_EX;
          default: b = 8'h00;
        endcase
      end
      OP_RD_LOCK: begin
        case (fr)
          3'd0: b = INS_CMD;
          3'd1: b = INS_RD_HI;
          3'd2: b = INS_END_HI;
          default: b = 8'h00;
        endcase
      end
      OP_WR_LFUSE, OP_WR_LOCK: begin
        case (fr)
          3'd0: b = INS_CMD;
          3'd1: b = INS_DLO;
          3'd2: b = INS_PLS_LO;
          3'd3: b = INS_END_LO;
          default: b = 8'h00;
        endcase
      end
      OP_WR_HFUSE: begin
        case (fr)
          3'd0: b = INS_CMD;
          3'd1: b = INS_DLO;
          3'd2: b = INS_PLS_HI;
          3'd3: b = INS_END_HI;
          default: b = 8'h00;
        endcase
      end
      OP_WR_EFUSE: begin
        case (fr)
          3'd0: b = INS_CMD;
          3'd1: b = INS_DLO;
          3'd2: b = INS_PLS_EX;
          3'd3: b = INS_END_EX;
          default: b = 8'h00;
        endcase
      end
      OP_ERASE: begin
        case (fr)
          3'd0: b = INS_CMD;
          3'd1: b = INS_PLS_LO;
          3'd2: b = INS_END_LO;
          default: b = 8'h00;
        endcase
      end
      OP_MODE_WR_FL, OP_MODE_RD_FL, OP_MODE_WR_EE, OP_MODE_RD_EE: begin
        if (fr == 3'd0) b = INS_CMD;
      end
      OP_LOAD_FL_LO: begin
        case (fr)
          3'd0: b = INS_ALO;
          3'd1: b = INS_DLO;
          default: b = 8'h00;
        endcase
      end
      OP_LOAD_FL_HI: begin
        case (fr)
          3'd0: b = INS_DHI;
          3'd1: b = INS_PAGE_HI;
          3'd2: b = INS_END_HI;
          default: b = 8'h00;
        endcase
      end
      OP_RD_FL_LO: begin
        case (fr)
          3'd0: b = INS_ALO;
          3'd1: b = INS_AHI;
          3'd2: b = INS_RD_LO;
          3'd3: b = INS_END_LO;
          default: b = 8'h00;
        endcase
      end
      OP_RD_FL_HI: begin
        case (fr)
          3'd0: b = INS_END_LO;
          3'd1: b = INS_RD_HI;
          3'd2: b = INS_END_HI;
          3'd3: b = INS_END_HI;
          default: b = 8'h00;
        endcase
      end
      OP_WR_FL_PAGE: begin
        case (fr)
          3'd0: b = INS_AHI;
          3'd1: b = INS_PLS_LO;
          3'd2: b = INS_END_LO;
          default: b = 8'h00;
        endcase
      end
      OP_LOAD_EE: begin
        case (fr)
          3'd0: b = INS_ALO;
          3'd1: b = INS_AHI;
          3'd2: b = INS_DLO;
          3'd3: b = INS_PAGE_EE;
          3'd4: b = INS_END_LO;
          default: b = 8'h00;
        endcase
      end
      OP_WR_EE_PAGE: begin
        case (fr)
          3'd0: b = INS_PLS_LO;
          3'd1: b = INS_END_LO;
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hvpe_if.sv @@
`default_nettype none

interface hvpe_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  func;
  logic [15:0] address;
  logic [7:0]  data_byte;
  logic [7:0]  sig_index;
  logic        sdo;

  modport source (output valid, func, address, data_byte, sig_index, sdo, input ready);
  modport sink   (input valid, func, address, data_byte, sig_index, sdo, output ready);
endinterface

interface hvpe_rsp_if;
  logic       valid;
  logic       ready;
  logic       sci_pulse;
  logic       sdi;
  logic       sii;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_value;
  logic       rejected;

  modport source (output valid, sci_pulse, sdi, sii, busy_res, done_res, read_value, rejected,
                  input ready);
  modport sink   (input valid, sci_pulse, sdi, sii, busy_res, done_res, read_value, rejected,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hv_serial_programming_engine.sv @@
`default_nettype none

// channel | dir | handshake        | beat
// req_i   | in  | valid/ready      | func, address, data_byte, sig_index, sdo
// rsp_o   | out | valid/ready      | sci_pulse, sdi, sii, busy_res, done_res, read_value, rejected
//
// one beat in, one beat out; a beat can enter every cycle while req_i ready is high, and its
// result passes through the queue, then the result register
// the sequencer in the back end handles one beat per cycle, so the queue only fills on stalls
// reset clears the sequencer to idle and empties the queue and result register
// a stalled rsp_o backs up into the queue, then req_i ready drops

module hv_serial_programming_engine
  import hvpe_pkg::*;
#(
  parameter int unsigned QueueDepth = HVPE_QUEUE_DEPTH
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  hvpe_req_if.sink   req_i,
  hvpe_rsp_if.source rsp_o
);

  logic  fr_valid, fr_ready;
  item_t fr_item;
  logic  bk_valid, bk_ready;
  item_t bk_item;

  hvpe_front u_front (
    .req_i        (req_i),
    .item_valid_o (fr_valid),
    .item_o       (fr_item),
    .item_ready_i (fr_ready)
  );

  hvpe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_item_i  (fr_item),
    .push_ready_o (fr_ready),
    .pop_valid_o  (bk_valid),
    .pop_item_o   (bk_item),
    .pop_ready_i  (bk_ready)
  );

  hvpe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (bk_valid),
    .item_i       (bk_item),
    .item_ready_o (bk_ready),
    .rsp_o        (rsp_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/hvpe_front.sv @@
`default_nettype none

module hvpe_front
  import hvpe_pkg::*;
(
  hvpe_req_if.sink req_i,
  output logic     item_valid_o,
  output item_t    item_o,
  input  logic     item_ready_i
);

  item_kind_e kind;

  always_comb begin
    if (req_i.func == OP_TICK) begin
      kind = KIND_TICK;
    end else if (req_i.func > OP_WR_EE_PAGE) begin
      kind = KIND_UNKNOWN;
    end else begin
      kind = KIND_START;
    end
  end

  assign item_valid_o = req_i.valid;
  assign req_i.ready  = item_ready_i;

  // signature read sends its index where other ops send the data byte
  always_comb begin
    item_o.kind    = kind;
    item_o.op      = req_i.func;
    item_o.address = req_i.address;
    item_o.held    = (req_i.func == OP_SIG_READ) ? req_i.sig_index : req_i.data_byte;
    item_o.sdo     = req_i.sdo;
  end

endmodule

`default_nettype wire

@@ hw/rtl/hvpe_fifo.sv @@
`default_nettype none

module hvpe_fifo
  import hvpe_pkg::*;
#(
  parameter int unsigned Depth = HVPE_QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  input  item_t push_item_i,
  output logic  push_ready_o,
  output logic  pop_valid_o,
  output item_t pop_item_o,
  input  logic  pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hvpe_back.sv @@
`default_nettype none

module hvpe_back
  import hvpe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  item_t      item_i,
  output logic       item_ready_o,
  hvpe_rsp_if.source rsp_o
);

  logic [4:0]  active_q, active_d;
  logic [2:0]  frame_q, frame_d;
  logic [3:0]  slot_q, slot_d;
  logic        wait_q, wait_d;
  logic [7:0]  cap_q, cap_d;
  logic [7:0]  held_q, held_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  page_q, page_d;
  logic [7:0]  hold_q, hold_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;

  logic        pop;
  result_t     res;
  data_src_t   src;
  logic [7:0]  data_b, instr_b, rd_byte;
  logic [2:0]  bit_idx, total, rd_frame;
  logic        last_frame;

  assign item_ready_o = !out_valid_q || rsp_o.ready;
  assign pop          = item_valid_i && item_ready_o;

  // frame lookups for the running op
  always_comb begin
    src      = data_src(active_q, frame_q);
    instr_b  = instr_byte(active_q, frame_q);
    total    = frame_total(active_q);
    rd_frame = read_frame(active_q);
    case (src.sel)
      SRC_HELD: data_b = held_q;
      SRC_ALO:  data_b = addr_q[7:0];
      SRC_AHI:  data_b = addr_q[15:8];
      SRC_PAGE: data_b = page_q;
      default:  data_b = src.value;
    endcase
    bit_idx    = 3'(SLOT_LAST_BIT - slot_q);
    last_frame = ({1'b0, frame_q} + 4'd1) >= {1'b0, total};
    rd_byte    = (frame_q == rd_frame) ? cap_q : hold_q;
  end

  always_comb begin
    active_d = active_q;
    frame_d  = frame_q;
    slot_d   = slot_q;
    wait_d   = wait_q;
    cap_d    = cap_q;
    held_d   = held_q;
    addr_d   = addr_q;
    page_d   = page_q;
    hold_d   = hold_q;
    res      = '0;
    if (pop) begin
      case (item_i.kind)
        KIND_START: begin
          res.busy_res = 1'b1;
          if (active_q != OP_TICK) begin
            res.rejected = 1'b1;
          end else begin
            active_d = item_i.op;
            frame_d  = '0;
            slot_d   = SLOT_IDLE;
            wait_d   = 1'b1;
            cap_d    = '0;
            held_d   = item_i.held;
            addr_d   = item_i.address;
            if (item_i.op == OP_LOAD_FL_LO) page_d = item_i.address[15:8];
          end
        end
        KIND_TICK: begin
          if (active_q == OP_TICK) begin
            res = '0;
          end else if (wait_q || slot_q == SLOT_IDLE) begin
            // hold off the start slot while the target pulls sdo low
            res.busy_res = 1'b1;
            if (item_i.sdo) begin
              wait_d        = 1'b0;
              slot_d        = SLOT_FIRST;
              res.sci_pulse = 1'b1;
            end
          end else if (slot_q <= SLOT_LAST_BIT) begin
            res.sci_pulse = 1'b1;
            res.busy_res  = 1'b1;
            res.sdi       = data_b[bit_idx];
            res.sii       = instr_b[bit_idx];
            if (item_i.sdo) cap_d[bit_idx] = 1'b1;
            slot_d = slot_q + 4'd1;
          end else if (slot_q == SLOT_STOP1) begin
            res.sci_pulse = 1'b1;
            res.busy_res  = 1'b1;
            slot_d        = SLOT_STOP2;
          end else begin
            res.sci_pulse = 1'b1;
            hold_d        = rd_byte;
            if (last_frame) begin
              res.done_res   = 1'b1;
              res.read_value = (rd_frame != NO_READ) ? rd_byte : 8'h00;
              active_d       = OP_TICK;
              frame_d        = '0;
              slot_d         = SLOT_IDLE;
              wait_d         = 1'b0;
            end else begin
              res.busy_res = 1'b1;
              frame_d      = frame_q + 3'd1;
              wait_d       = 1'b1;
              slot_d       = SLOT_IDLE;
              cap_d        = '0;
            end
          end
        end
        default: begin
          res.busy_res = (active_q != OP_TICK);
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (pop) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= OP_TICK;
      frame_q     <= '0;
      slot_q      <= SLOT_IDLE;
      wait_q      <= 1'b0;
      cap_q       <= '0;
      held_q      <= '0;
      addr_q      <= '0;
      page_q      <= '0;
      hold_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      frame_q     <= frame_d;
      slot_q      <= slot_d;
      wait_q      <= wait_d;
      cap_q       <= cap_d;
      held_q      <= held_d;
      addr_q      <= addr_d;
      page_q      <= page_d;
      hold_q      <= hold_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.sci_pulse  = out_q.sci_pulse;
  assign rsp_o.sdi        = out_q.sdi;
  assign rsp_o.sii        = out_q.sii;
  assign rsp_o.busy_res   = out_q.busy_res;
  assign rsp_o.done_res   = out_q.done_res;
  assign rsp_o.read_value = out_q.read_value;
  assign rsp_o.rejected   = out_q.rejected;

endmodule

`default_nettype wire
